### hw/rtl/gfe_pkg.sv
// Package with the payload beat types and fixed constants of the GEP fitness evaluator.
package gfe_pkg;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [2:0] REG_COMBINE_OP      = 3'd0;
	localparam logic [2:0] REG_CLASSIFY_MODE   = 3'd1;
	localparam logic [2:0] REG_ABSOLUTE_ERROR  = 3'd2;
	localparam logic [2:0] REG_CLASS_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_SELECTION_RANGE = 3'd4;

	localparam int SUM_W = 48;

	typedef struct packed {
		logic signed [31:0] gene_value;
		logic               gene_deadly;
		logic               last_gene;
		logic signed [31:0] target_value;
		logic               last_sample;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic [47:0]        fitness;
		logic               fitness_valid;
		logic               individual_deadly;
	} out_beat_t;

endpackage

### hw/rtl/gep_fitness_evaluator_core.sv
// Top level of the GEP fitness evaluator: sequencer, shared divider and scoring logic.
//
//  channel | direction | handshake           | payload
//  in      | to core   | in_valid/in_stall   | gfe_pkg::in_beat_t
//  out     | from core | out_valid/out_stall | gfe_pkg::out_beat_t
//  cfg     | to core   | cfg_we              | cfg_index, cfg_data
//
// A gene that seeds a multiply or divide goes from ST_IDLE straight to ST_COMB_DONE; any other
// add, subtract or multiply gene passes through ST_MUL first, and a divide gene through ST_DIV,
// where the shared restoring divider retires one of its 40 + FRAC_BITS bits per cycle.
// The last gene of a sample adds a scoring pass through ST_SCORE and ST_FINISH, with ST_REL_DIV
// between them in relative mode for a nonzero target, where the same divider forms |100*d/t|.
// Reset clears all configuration to its reset values and starts a new individual.
// A result beat waits in the output register while out_stall is high. Input beats are still
// taken meanwhile; only the end of the next scoring pass waits until that result is taken.
module gep_fitness_evaluator_core #(
	parameter int FRAC_BITS   = 16,
	parameter int MAX_SAMPLES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  gfe_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output gfe_pkg::out_beat_t  out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	// Dividend width: relative mode divides (100*mag) << FRAC_BITS, up to 40+FRAC_BITS bits.
	localparam int DVD_W = 40 + FRAC_BITS;
	localparam int DBW   = $clog2(DVD_W + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
	localparam logic [47:0] TENTH_Q = 48'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
	localparam logic [47:0] SUM_MAX = {48{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DIV, ST_COMB_DONE, ST_SCORE, ST_REL_DIV, ST_FINISH, ST_OUT
	} state_t;

	state_t state_q;

	logic [1:0]         combine_op_q;
	logic               classify_mode_q;
	logic               absolute_error_q;
	logic signed [31:0] class_threshold_q;
	logic [30:0]        selection_range_q;

	logic signed [31:0] acc_q;
	logic               first_q;
	logic               deadly_q;
	logic [CNT_W-1:0]   match_q;
	logic [CNT_W-1:0]   samples_q;
	logic [47:0]        sum_q;
	gfe_pkg::in_beat_t  beat_q;
	logic [1:0]         op_q;
	logic signed [63:0] prod_q;

	// Shared divider: restoring, unsigned, one quotient bit per cycle.
	logic [DVD_W-1:0]   dvd_q;
	logic [32:0]        dvs_q;
	logic [33:0]        rem_q;
	logic [DVD_W-1:0]   quo_q;
	logic [DBW-1:0]     dcnt_q;
	logic               neg_q;
	logic [32:0]        mag_q;
	logic [47:0]        term_q;

	gfe_pkg::out_beat_t out_q;
	logic               out_valid_q;

	logic in_acc;
	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Divider step values.
	logic [33:0] rem_sh;
	logic [34:0] rem_sub;
	assign rem_sh  = {rem_q[32:0], dvd_q[DVD_W-1]};
	assign rem_sub = {1'b0, rem_sh} - {2'b0, dvs_q};

	// Combining for add and subtract, and multiply scaling of the registered product.
	logic signed [31:0] acc_base;
	logic signed [31:0] add_res;
	logic signed [31:0] mul_res;
	logic signed [31:0] div_res;
	assign acc_base = first_q ? 32'sd0 : acc_q;
	assign add_res = (op_q == gfe_pkg::OP_ADD)
		? sat32(64'(acc_base) + 64'(beat_q.gene_value))
		: sat32(64'(acc_base) - 64'(beat_q.gene_value));
	assign mul_res = sat32(prod_q >>> FRAC_BITS);
	// A quotient magnitude of 2^31 or more saturates in the direction of its sign.
	assign div_res = (|(quo_q >> 31)) ? (neg_q ? 32'sh80000000 : 32'sh7fffffff)
	                                  : (neg_q ? -$signed({1'b0, quo_q[30:0]})
	                                           : $signed({1'b0, quo_q[30:0]}));

	// Scoring helpers.
	logic signed [31:0] sval;
	logic signed [32:0] diff;
	logic [47:0]        err_rel;
	logic [47:0]        term_from;
	assign sval = classify_mode_q ? ((acc_q > class_threshold_q) ? 32'(ONE_Q) : 32'sd0) : acc_q;
	assign diff = 33'(acc_q) - 33'(beat_q.target_value);
	assign err_rel = quo_q[47:0];

	function automatic logic [47:0] range_minus(input logic [47:0] e, input logic [30:0] r);
		if (e >= {17'd0, r}) return TENTH_Q;
		return {17'd0, r} - e;
	endfunction
	assign term_from = range_minus(absolute_error_q ? {15'd0, mag_q} : err_rel, selection_range_q);

	logic [48:0] sum_next;
	assign sum_next = {1'b0, sum_q} + {1'b0, term_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			combine_op_q      <= gfe_pkg::OP_ADD;
			classify_mode_q   <= 1'b0;
			absolute_error_q  <= 1'b1;
			class_threshold_q <= '0;
			selection_range_q <= 31'd6553600;
			acc_q             <= '0;
			first_q           <= 1'b1;
			deadly_q          <= 1'b0;
			match_q           <= '0;
			samples_q         <= '0;
			sum_q             <= '0;
			out_valid_q       <= 1'b0;
			dcnt_q            <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gfe_pkg::REG_COMBINE_OP:      combine_op_q      <= cfg_data[1:0];
					gfe_pkg::REG_CLASSIFY_MODE:   classify_mode_q   <= cfg_data[0];
					gfe_pkg::REG_ABSOLUTE_ERROR:  absolute_error_q  <= cfg_data[0];
					gfe_pkg::REG_CLASS_THRESHOLD: class_threshold_q <= cfg_data;
					gfe_pkg::REG_SELECTION_RANGE: selection_range_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						beat_q <= in_data;
						op_q   <= combine_op_q;
						if (in_data.gene_deadly) deadly_q <= 1'b1;
						if (first_q && combine_op_q[1]) begin
							acc_q   <= in_data.gene_value;
							first_q <= 1'b0;
							state_q <= ST_COMB_DONE;
						end else begin
							case (combine_op_q)
								gfe_pkg::OP_MUL: begin
									prod_q  <= 64'(acc_q) * 64'(in_data.gene_value);
									state_q <= ST_MUL;
								end
								gfe_pkg::OP_DIV: begin
									neg_q  <= acc_q[31] ^ in_data.gene_value[31];
									dvd_q  <= DVD_W'(acc_q[31] ? -64'(acc_q) : 64'(acc_q))
									          << FRAC_BITS;
									dvs_q  <= in_data.gene_value[31] ? -33'(in_data.gene_value)
									                                 : 33'(in_data.gene_value);
									rem_q  <= '0;
									quo_q  <= '0;
									dcnt_q <= DBW'(DVD_W);
									state_q <= ST_DIV;
								end
								default: begin
									state_q <= ST_MUL;
								end
							endcase
						end
					end
				end
				ST_MUL: begin
					acc_q   <= (op_q == gfe_pkg::OP_MUL) ? mul_res : add_res;
					first_q <= 1'b0;
					state_q <= ST_COMB_DONE;
				end
				ST_DIV: begin
					if (dcnt_q != '0) begin
						dvd_q  <= dvd_q << 1;
						dcnt_q <= dcnt_q - 1'b1;
						if (!rem_sub[34]) begin
							rem_q <= rem_sub[33:0];
							quo_q <= {quo_q[DVD_W-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[DVD_W-2:0], 1'b0};
						end
					end else begin
						acc_q   <= (dvs_q == '0) ? 32'sd0 : div_res;
						first_q <= 1'b0;
						state_q <= ST_COMB_DONE;
					end
				end
				ST_COMB_DONE: begin
					if (!beat_q.last_gene) begin
						state_q <= ST_IDLE;
					end else begin
						mag_q   <= diff[32] ? 33'(-diff) : 33'(diff);
						state_q <= ST_SCORE;
					end
				end
				ST_SCORE: begin
					if (absolute_error_q) begin
						term_q  <= term_from;
						state_q <= ST_FINISH;
					end else if (beat_q.target_value == 32'sd0) begin
						term_q  <= TENTH_Q;
						state_q <= ST_FINISH;
					end else begin
						dvd_q  <= DVD_W'(40'(mag_q) * 40'd100) << FRAC_BITS;
						dvs_q  <= beat_q.target_value[31] ? -33'(beat_q.target_value)
						                                  : 33'(beat_q.target_value);
						rem_q  <= '0;
						quo_q  <= '0;
						dcnt_q <= DBW'(DVD_W);
						state_q <= ST_REL_DIV;
					end
				end
				ST_REL_DIV: begin
					if (dcnt_q != '0) begin
						dvd_q  <= dvd_q << 1;
						dcnt_q <= dcnt_q - 1'b1;
						if (!rem_sub[34]) begin
							rem_q <= rem_sub[33:0];
							quo_q <= {quo_q[DVD_W-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[DVD_W-2:0], 1'b0};
						end
					end else begin
						// An error of 2^48 or more is beyond any selection range and
						// scores as a tenth.
						term_q <= (|(quo_q >> 48)) ? TENTH_Q : term_from;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// The previous result beat has to leave the output register first.
					if (!out_valid_q) begin
						logic [CNT_W-1:0] m;
						logic [CNT_W-1:0] s;
						logic [47:0]      fs;
						logic [47:0]      fit;
						m  = (sval == beat_q.target_value && match_q < CNT_MAX)
						     ? match_q + 1'b1 : match_q;
						s  = (samples_q < CNT_MAX) ? samples_q + 1'b1 : samples_q;
						fs = sum_next[48] ? SUM_MAX : sum_next[47:0];
						fit = '0;
						if (beat_q.last_sample) begin
							if (!deadly_q)
								fit = classify_mode_q ? ((m > (s >> 1)) ? 48'(m) : 48'd1)
								                      : fs;
							match_q   <= '0;
							samples_q <= '0;
							sum_q     <= '0;
							deadly_q  <= 1'b0;
						end else begin
							match_q   <= m;
							samples_q <= s;
							sum_q     <= fs;
						end
						out_q.sample_value      <= sval;
						out_q.individual_deadly <= deadly_q;
						out_q.fitness_valid     <= beat_q.last_sample;
						out_q.fitness           <= fit;
						acc_q   <= '0;
						first_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The core takes no beat while busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input accepted while busy");
	// A fitness is reported only together with a finished individual.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.fitness_valid) |-> (out_q.fitness == '0))
		else $error("fitness on a non-final sample");
	// Divider counter stays within its range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(dcnt_q <= DBW'(DVD_W)))
		else $error("divider counter out of range");
	// Sample counters never pass their limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(match_q <= CNT_MAX) && (samples_q <= CNT_MAX))
		else $error("sample counter overflow");

endmodule
